@@ design/mi3_pkg.sv @@
// shared widths, types and cofactor index tables for the 3x3 matrix inverse
package mi3_pkg;

  localparam int unsigned IN_W     = 16;
  localparam int unsigned IN_FRAC  = 8;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned OUT_FRAC = 16;
  localparam int unsigned N_ELEM   = 9;

  localparam int unsigned IN_DATA_W  = N_ELEM * IN_W;
  localparam int unsigned OUT_DATA_W = N_ELEM * OUT_W;
  localparam int unsigned OUT_USER_W = 2;

  localparam int unsigned PROD_W = 2 * IN_W;
  localparam int unsigned ADJ_W  = PROD_W + 1;
  localparam int unsigned MAG_W  = PROD_W;
  localparam int unsigned TERM_W = IN_W + ADJ_W;
  localparam int unsigned DET_W  = TERM_W + 2;
  localparam int unsigned DM_W   = DET_W - 1;
  localparam int unsigned DIV_W  = DM_W + 1;
  localparam int unsigned SHIFT  = IN_FRAC + OUT_FRAC;
  localparam int unsigned NUM_W  = MAG_W + SHIFT + 2;
  localparam int unsigned Q_W    = OUT_W;

  localparam int unsigned USER_SINGULAR  = 0;
  localparam int unsigned USER_SATURATED = 1;

  typedef logic signed [IN_W-1:0]   elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [NUM_W-1:0]         num_t;
  typedef logic [DIV_W-1:0]         div_t;
  typedef logic [Q_W-1:0]           quot_t;

  typedef logic [3:0] idx_t;
  typedef idx_t idx_tab_t [N_ELEM];

  // adj[k] = a[PA[k]] * a[PB[k]] - a[PC[k]] * a[PD[k]], k = row * 3 + column
  localparam idx_tab_t PA = '{4'd4, 4'd7, 4'd1, 4'd5, 4'd8, 4'd2, 4'd3, 4'd6, 4'd0};
  localparam idx_tab_t PB = '{4'd8, 4'd2, 4'd5, 4'd6, 4'd0, 4'd3, 4'd7, 4'd1, 4'd4};
  localparam idx_tab_t PC = '{4'd5, 4'd8, 4'd2, 4'd3, 4'd6, 4'd0, 4'd6, 4'd7, 4'd3};
  localparam idx_tab_t PD = '{4'd7, 4'd1, 4'd4, 4'd8, 4'd2, 4'd5, 4'd4, 4'd0, 4'd1};

endpackage

@@ design/matrix_inverse_3x3.sv @@
// 3x3 matrix inverse by adjugate over determinant, one matrix per unstalled cycle
//
//  channel  | direction | tdata                          | tuser
//  s_axis   | in        | a00..a22, 16 bits each, a00 low | -
//  m_axis   | out       | b00..b22, 32 bits each, b00 low | singular, saturated
//
// a new matrix can enter every cycle unless the output stalls; on its way it passes
// the input register, products, cofactors, determinant terms, determinant, dividend
// set-up, overflow check, 32 quotient-bit stages of nine dividers, output register
// reset clears only the valid bits; no clearing pass
// a stall at the output freezes the whole pipeline, so nothing is lost or repeated
module matrix_inverse_3x3 (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22 from the lowest bit up
  input  logic [mi3_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // b00, b01, b02, b10, b11, b12, b20, b21, b22 from the lowest bit up
  output logic [mi3_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // singular, saturated from the lowest bit up
  output logic [mi3_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
  import mi3_pkg::*;

  logic en;

  // stage 1: input register
  elem_t a1_q [N_ELEM];
  logic  v1_q;
  // stage 2: products
  prod_t pl2_q [N_ELEM];
  prod_t pr2_q [N_ELEM];
  elem_t r2_q  [3];
  logic  v2_q;
  // stage 3: cofactors
  adj_t  adj3_q [N_ELEM];
  elem_t r3_q   [3];
  logic  v3_q;
  // stage 4: determinant terms
  adj_t  adj4_q [N_ELEM];
  term_t t4_q   [3];
  logic  v4_q;
  // stage 5: determinant
  adj_t  adj5_q [N_ELEM];
  det_t  det5_q;
  logic  v5_q;
  // stage 6: rounding dividend and divisor
  num_t  n6_q   [N_ELEM];
  logic  neg6_q [N_ELEM];
  div_t  d6_q;
  logic  sing6_q;
  logic  v6_q;
  // divider pipeline, index 0 is the overflow-check stage
  num_t  rem_q  [Q_W+1][N_ELEM];
  quot_t quo_q  [Q_W+1][N_ELEM];
  logic  ovf_q  [Q_W+1][N_ELEM];
  logic  neg_q  [Q_W+1][N_ELEM];
  div_t  dv_q   [Q_W+1];
  logic  sing_q [Q_W+1];
  logic  vd_q   [Q_W+1];
  // output register
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;
  logic                  out_v_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      vd_q    <= '{default: 1'b0};
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q     <= s_axis_tvalid;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      v6_q     <= v5_q;
      vd_q[0]  <= v6_q;
      for (int s = 0; s < Q_W; s++) begin
        vd_q[s+1] <= vd_q[s];
      end
      out_v_q  <= vd_q[Q_W];
    end
  end

  // front stages up to the dividend set-up
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < N_ELEM; i++) begin
        a1_q[i] <= s_axis_tdata[i*IN_W +: IN_W];
      end

      for (int i = 0; i < N_ELEM; i++) begin
        pl2_q[i] <= a1_q[PA[i]] * a1_q[PB[i]];
        pr2_q[i] <= a1_q[PC[i]] * a1_q[PD[i]];
      end
      for (int i = 0; i < 3; i++) begin
        r2_q[i] <= a1_q[i];
      end

      for (int i = 0; i < N_ELEM; i++) begin
        adj3_q[i] <= ADJ_W'(pl2_q[i]) - ADJ_W'(pr2_q[i]);
      end
      r3_q <= r2_q;

      // first-row expansion uses the first column of the adjugate
      for (int i = 0; i < 3; i++) begin
        t4_q[i] <= TERM_W'(r3_q[i]) * TERM_W'(adj3_q[3*i]);
      end
      adj4_q <= adj3_q;

      det5_q <= DET_W'(t4_q[0]) + DET_W'(t4_q[1]) + DET_W'(t4_q[2]);
      adj5_q <= adj4_q;
    end
  end

  // dividend 2*|adj|*2^SHIFT + |det| and divisor 2*|det| give round half away
  always_ff @(posedge clk_i) begin
    logic [DET_W-1:0] dabs;
    logic [ADJ_W-1:0] aabs;
    if (en) begin
      dabs = det5_q[DET_W-1] ? DET_W'(-det5_q) : DET_W'(det5_q);
      d6_q    <= {dabs[DM_W-1:0], 1'b0};
      sing6_q <= (det5_q == '0);
      for (int i = 0; i < N_ELEM; i++) begin
        aabs = adj5_q[i][ADJ_W-1] ? ADJ_W'(-adj5_q[i]) : ADJ_W'(adj5_q[i]);
        n6_q[i]   <= (NUM_W'(aabs[MAG_W-1:0]) << (SHIFT + 1)) + NUM_W'(dabs[DM_W-1:0]);
        neg6_q[i] <= adj5_q[i][ADJ_W-1] ^ det5_q[DET_W-1];
      end
    end
  end

  // a quotient of 2^Q_W or more saturates unless the matrix is singular
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0]   <= d6_q;
      sing_q[0] <= sing6_q;
      for (int i = 0; i < N_ELEM; i++) begin
        rem_q[0][i] <= n6_q[i];
        quo_q[0][i] <= '0;
        ovf_q[0][i] <= (n6_q[i] >> Q_W) >= NUM_W'(d6_q);
        neg_q[0][i] <= neg6_q[i];
      end
    end
  end

  // one restoring quotient bit per stage, most significant first
  for (genvar s = 0; s < Q_W; s++) begin : g_div
    localparam int unsigned K = Q_W - 1 - s;
    num_t  rem_d [N_ELEM];
    logic  bit_d [N_ELEM];
    quot_t quo_d [N_ELEM];

    always_comb begin
      for (int i = 0; i < N_ELEM; i++) begin
        bit_d[i] = (rem_q[s][i] >> K) >= NUM_W'(dv_q[s]);
        rem_d[i] = bit_d[i] ? rem_q[s][i] - (NUM_W'(dv_q[s]) << K) : rem_q[s][i];
        quo_d[i]    = quo_q[s][i];
        quo_d[i][K] = bit_d[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[s+1]   <= dv_q[s];
        sing_q[s+1] <= sing_q[s];
        for (int i = 0; i < N_ELEM; i++) begin
          rem_q[s+1][i] <= rem_d[i];
          quo_q[s+1][i] <= quo_d[i];
          ovf_q[s+1][i] <= ovf_q[s][i];
          neg_q[s+1][i] <= neg_q[s][i];
        end
      end
    end
  end

  // sign, saturation and the singular case
  always_ff @(posedge clk_i) begin
    logic        sat;
    logic        clip;
    quot_t       q;
    logic [OUT_W-1:0] v;
    if (en) begin
      sat = 1'b0;
      for (int i = 0; i < N_ELEM; i++) begin
        q = quo_q[Q_W][i];
        if (!neg_q[Q_W][i]) begin
          clip = ovf_q[Q_W][i] || q[Q_W-1];
          v    = clip ? {1'b0, {(OUT_W-1){1'b1}}} : q;
        end else begin
          clip = ovf_q[Q_W][i] || (q[Q_W-1] && (q[Q_W-2:0] != '0));
          v    = clip ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-q);
        end
        if (sing_q[Q_W]) begin
          v    = '0;
          clip = 1'b0;
        end
        sat = sat | clip;
        out_data_q[i*OUT_W +: OUT_W] <= v;
      end
      out_user_q[USER_SINGULAR]  <= sing_q[Q_W];
      out_user_q[USER_SATURATED] <= sat;
    end
  end

  a_sing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[USER_SINGULAR]) |->
      (m_axis_tdata == '0 && !m_axis_tuser[USER_SATURATED]))
    else $error("singular result with non-zero data or saturation");

  a_stall_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while the pipeline is stalled");

  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (vd_q[0] == $past(vd_q[0]) && v1_q == $past(v1_q)))
    else $error("pipeline valid bit moved during a stall");

  a_flow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vd_q[Q_W]) |=> m_axis_tvalid)
    else $error("result lost at the output register");

endmodule

@@ sim/matrix_inverse_3x3_tb.sv @@
// testbench for the 3x3 matrix inverse: random and directed matrices, scoreboard check
`timescale 1ns / 1ps

module matrix_inverse_3x3_tb;
  import mi3_pkg::*;

  typedef struct {
    logic [OUT_DATA_W-1:0] inv;
    logic                  singular;
    logic                  saturated;
  } inv_result_t;

  class inverse_board;
    inv_result_t pending[$];
    int unsigned errors;
    int unsigned n_checked;
    int unsigned n_singular;
    int unsigned n_saturated;

    function automatic logic signed [63:0] el(logic [IN_DATA_W-1:0] d, int k);
      logic signed [15:0] v;
      v = d[k*IN_W +: IN_W];
      return 64'(v);
    endfunction

    // exact adjugate over determinant, rounded half away from zero, clipped
    function void note_request(logic [IN_DATA_W-1:0] d);
      logic signed [63:0] a [9];
      logic signed [63:0] adj [9];
      logic signed [63:0] det;
      logic [63:0] dm, num, q, lim;
      logic neg, dneg;
      inv_result_t r;
      for (int k = 0; k < 9; k++) a[k] = el(d, k);
      adj[0] = a[4]*a[8] - a[5]*a[7];
      adj[1] = a[7]*a[2] - a[8]*a[1];
      adj[2] = a[1]*a[5] - a[2]*a[4];
      adj[3] = a[5]*a[6] - a[3]*a[8];
      adj[4] = a[8]*a[0] - a[6]*a[2];
      adj[5] = a[2]*a[3] - a[0]*a[5];
      adj[6] = a[3]*a[7] - a[6]*a[4];
      adj[7] = a[6]*a[1] - a[7]*a[0];
      adj[8] = a[0]*a[4] - a[3]*a[1];
      det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
      r.inv = '0;
      r.singular = (det == 0);
      r.saturated = 1'b0;
      if (det != 0) begin
        dneg = det < 0;
        dm = dneg ? -det : det;
        for (int k = 0; k < 9; k++) begin
          neg = (adj[k] < 0) != dneg;
          num = (adj[k] < 0 ? -adj[k] : adj[k]) << (IN_FRAC + OUT_FRAC);
          q = (num * 2 + dm) / (dm * 2);
          lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
          if (q > lim) begin
            q = lim;
            r.saturated = 1'b1;
          end
          r.inv[k*OUT_W +: OUT_W] = neg ? 32'(-q) : 32'(q);
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u);
      inv_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (e.singular) n_singular++;
      if (e.saturated) n_saturated++;
      for (int k = 0; k < 9; k++)
        if (d[k*OUT_W +: OUT_W] !== e.inv[k*OUT_W +: OUT_W]) begin
          $display("%0t: b%0d%0d expected %h actual %h", $realtime, k/3, k%3,
                   e.inv[k*OUT_W +: OUT_W], d[k*OUT_W +: OUT_W]);
          errors++;
        end
      if (u[USER_SINGULAR] !== e.singular) begin
        $display("%0t: singular expected %b actual %b", $realtime, e.singular,
                 u[USER_SINGULAR]);
        errors++;
      end
      if (u[USER_SATURATED] !== e.saturated) begin
        $display("%0t: saturated expected %b actual %b", $realtime, e.saturated,
                 u[USER_SATURATED]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  inverse_board board = new();
  bit sender_quiet = 1'b0;
  bit receiver_quiet = 1'b0;
  bit long_hold = 1'b0;
  bit sending_done = 1'b0;
  int unsigned n_sent = 0;

  always #6 clk_i = ~clk_i;

  matrix_inverse_3x3 u_top (.*);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tuser);
  end

  // receiver side stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) m_axis_tready <= 1'b0;
      else m_axis_tready <= receiver_quiet || ($urandom_range(99) >= 24);
    end
  end

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(512)) - 256);
      2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(2048)) - 1024);
    endcase
  endfunction

  task automatic send_matrix(logic [IN_DATA_W-1:0] d);
    while (!sender_quiet && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(d);
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack(logic [15:0] e [9]);
    logic [IN_DATA_W-1:0] d;
    for (int k = 0; k < 9; k++) d[k*IN_W +: IN_W] = e[k];
    return d;
  endfunction

  function automatic logic [IN_DATA_W-1:0] diag(logic [15:0] x, logic [15:0] y,
                                                logic [15:0] z);
    logic [15:0] e [9];
    e = '{default: 16'h0};
    e[0] = x; e[4] = y; e[8] = z;
    return pack(e);
  endfunction

  task automatic directed_matrices();
    logic [15:0] e [9];
    send_matrix(diag(16'h0100, 16'h0100, 16'h0100));   // identity
    send_matrix('0);                                    // all zero, singular
    send_matrix({IN_DATA_W{1'b1}});                     // all -1 lsb, singular
    send_matrix(diag(16'h0001, 16'h0001, 16'h0001));   // tiny, large inverse but in range
    send_matrix(diag(16'hffff, 16'hffff, 16'hffff));   // tiny negative
    send_matrix(diag(16'h7fff, 16'h7fff, 16'h7fff));   // largest, results round small
    send_matrix(diag(16'h8000, 16'h8000, 16'h8000));
    send_matrix(diag(16'h8000, 16'h7fff, 16'h0001));
    send_matrix(diag(16'h0200, 16'hfe00, 16'h0080));
    e = '{16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600,
          16'h0700, 16'h0800, 16'h0900};                // rank two, singular
    send_matrix(pack(e));
    e = '{16'h0200, 16'h0100, 16'h0000, 16'h0100, 16'h0300, 16'h0100,
          16'h0000, 16'h0100, 16'h0400};
    send_matrix(pack(e));
    e = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
          16'h7fff, 16'h8000, 16'h0001};
    send_matrix(pack(e));
    e = '{16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
          16'h0100, 16'h0000, 16'h0000};                // permutation
    send_matrix(pack(e));
    // rounding: quotients that are not exact, such as thirds
    send_matrix(diag(16'h0003, 16'h0100, 16'h0100));
    send_matrix(diag(16'h0300, 16'h0100, 16'hfd00));
  endtask

  initial begin
    logic [15:0] e [9];
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed_matrices();
    for (int i = 0; i < 840; i++) begin
      sender_quiet = (i >= 300 && i < 400);
      receiver_quiet = (i >= 300 && i < 400);
      if (i == 500) long_hold = 1'b1;
      for (int k = 0; k < 9; k++) e[k] = rand_elem();
      // some near-singular and singular matrices: copy or negate a row
      if ($urandom_range(9) == 0)
        for (int k = 0; k < 3; k++) e[6+k] = e[3+k];
      if ($urandom_range(15) == 0)
        for (int k = 0; k < 3; k++) e[k] = -e[3+k];
      send_matrix(pack(e));
    end
    s_axis_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // long output stall so the pipeline fills and backs up the input
  initial begin
    wait (long_hold);
    repeat (200) @(posedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated)",
             n_sent, board.n_checked, board.n_singular, board.n_saturated);
    $display("random stalls on both sides plus one long output back-pressure stretch");
    if (board.errors == 0 && board.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
